[design/deq_pkg.sv]
package deq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4,
        OP_INVALID    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    localparam int FUNC_W  = 3;
    localparam int VALUE_W = 32;

    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] value;
    } req_t;

endpackage

[design/deq_front.sv]
module deq_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [deq_pkg::FUNC_W-1:0]  func,
    input  logic [deq_pkg::VALUE_W-1:0] value,
    output logic                        req_valid,
    input  logic                        req_ready,
    output deq_pkg::req_t               req
);

    deq_pkg::op_t op;

    always_comb begin
        case (func)
            deq_pkg::OP_PUSH_FRONT: op = deq_pkg::OP_PUSH_FRONT;
            deq_pkg::OP_PUSH_BACK:  op = deq_pkg::OP_PUSH_BACK;
            deq_pkg::OP_POP_FRONT:  op = deq_pkg::OP_POP_FRONT;
            deq_pkg::OP_POP_BACK:   op = deq_pkg::OP_POP_BACK;
            deq_pkg::OP_DUMP:       op = deq_pkg::OP_DUMP;
            default:                op = deq_pkg::OP_INVALID;
        endcase
    end

    assign req_valid = s_tvalid;
    assign s_tready  = req_ready;
    assign req.op    = op;
    assign req.value = value;

endmodule

[design/deq_fifo.sv]
module deq_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  deq_pkg::req_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output deq_pkg::req_t pop_data
);

    deq_pkg::req_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/deq_back.sv]
module deq_back #(
    parameter int DEPTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  deq_pkg::req_t               req,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [deq_pkg::VALUE_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast,
    output logic [$clog2(DEPTH+1)-1:0]  entry_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = PW + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic [deq_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [deq_pkg::VALUE_W-1:0] rd_data_reg;

    logic          state_reg, state_next;
    logic [PW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] rd_addr;
    logic          wr_en;
    logic [PW-1:0] wr_addr;

    logic                        out_valid_reg, out_valid_next;
    logic [deq_pkg::VALUE_W-1:0] out_data_reg, out_data_next;
    logic [1:0]                  out_status_reg, out_status_next;
    logic                        out_last_reg, out_last_next;

    logic          out_free;
    logic          is_full, is_empty;
    logic [SW-1:0] back_sum;
    logic [PW-1:0] back_addr;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
    endfunction

    assign out_free  = !out_valid_reg || m_tready;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign back_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_addr = (back_sum >= SW'(DEPTH)) ? PW'(back_sum - SW'(DEPTH)) : PW'(back_sum);
    assign req_ready = (state_reg == S_IDLE) && out_free;

    always_comb begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        rd_ptr_next     = rd_ptr_reg;
        rd_addr         = rd_ptr_reg;
        wr_en           = 1'b0;
        wr_addr         = back_addr;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE: begin
                if (req_valid && out_free) begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = deq_pkg::ST_OK;
                    case (req.op)
                        deq_pkg::OP_PUSH_FRONT: begin
                            if (is_full) begin
                                out_status_next = deq_pkg::ST_FULL;
                            end else begin
                                front_next = ptr_dec(front_reg);
                                wr_en      = 1'b1;
                                wr_addr    = ptr_dec(front_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        deq_pkg::OP_PUSH_BACK: begin
                            if (is_full) begin
                                out_status_next = deq_pkg::ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        deq_pkg::OP_POP_FRONT: begin
                            if (is_empty) begin
                                out_status_next = deq_pkg::ST_EMPTY;
                            end else begin
                                front_next = ptr_inc(front_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        deq_pkg::OP_POP_BACK: begin
                            if (is_empty) begin
                                out_status_next = deq_pkg::ST_EMPTY;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        deq_pkg::OP_DUMP: begin
                            if (is_empty) begin
                                out_status_next = deq_pkg::ST_EMPTY;
                            end else begin
                                out_valid_next = out_valid_reg && !m_tready;
                                state_next     = S_DUMP;
                                idx_next       = '0;
                                rd_ptr_next    = front_reg;
                                rd_addr        = front_reg;
                            end
                        end
                        default: begin
                            out_status_next = deq_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_data_next   = rd_data_reg;
                    out_status_next = deq_pkg::ST_OK;
                    out_last_next   = (idx_reg + 1'b1 == count_reg);
                    idx_next        = idx_reg + 1'b1;
                    rd_ptr_next     = ptr_inc(rd_ptr_reg);
                    rd_addr         = ptr_inc(rd_ptr_reg);
                    if (idx_reg + 1'b1 == count_reg) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        rd_ptr_reg     <= rd_ptr_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= req.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;
    assign m_tuser     = out_status_reg;
    assign m_tlast     = out_last_reg;
    assign entry_count = count_reg;

endmodule

[design/double_ended_queue_unit.sv]
// Bounded double-ended queue of 32-bit signed values in a DEPTH-entry ring memory.
// Every request gives one result (status ok, empty, full or invalid), except a dump of a
// non-empty queue, which gives one result per entry from front to back with m_tlast on the
// final one. A two-entry request queue sits between the input decoder and the execution
// unit, and results leave through a single output register. Push, pop and invalid requests
// are finished by the execution unit as it takes them; a dump reads the front entry from the
// ring memory, then gives one entry per cycle while the output register is free, taking no
// new request until done. Results pass the request queue and the output register, the first
// dump result also the memory read register. No clearing pass is needed after reset.
module double_ended_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [2:0]  s_tuser,   // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // item_value[31:0]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);

    logic                       fe_valid, fe_ready;
    deq_pkg::req_t              fe_req;
    logic                       be_valid, be_ready;
    deq_pkg::req_t              be_req;
    logic [$clog2(DEPTH+1)-1:0] entry_count;

    deq_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .func      (s_tuser),
        .value     (s_tdata),
        .req_valid (fe_valid),
        .req_ready (fe_ready),
        .req       (fe_req)
    );

    deq_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  (fe_req),
        .pop_valid  (be_valid),
        .pop_ready  (be_ready),
        .pop_data   (be_req)
    );

    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (be_valid),
        .req_ready   (be_ready),
        .req         (be_req),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .entry_count (entry_count)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count <= ($clog2(DEPTH+1))'(DEPTH))
        else $error("entry count above depth");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != deq_pkg::ST_OK) |-> m_tlast && (m_tdata == '0))
        else $error("non-ok result must be final and carry zero");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == deq_pkg::ST_FULL) |->
            entry_count == ($clog2(DEPTH+1))'(DEPTH))
        else $error("full result with queue not full");

endmodule

[dv/double_ended_queue_checker.sv]
module double_ended_queue_checker #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [2:0]  s_tuser,   // func[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // item_value[31:0]
    input  logic [1:0]  m_tuser,   // status[1:0]
    input  logic        m_tlast,
    output int          error_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTS = 30;

    typedef struct packed {
        deq_pkg::status_t status;
        logic [31:0]      value;
        logic             last;
    } deque_result_t;

    deque_result_t due_results[$];
    deque_result_t oldest;
    logic [31:0]   ring [DEPTH];
    int            front;
    int            count;
    int            printed;

    task automatic report_mismatch(input string msg);
        if (printed < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        printed++;
        error_count++;
    endtask

    task automatic expect_result(input deq_pkg::status_t status, input logic [31:0] value,
                                 input logic last);
        deque_result_t r;
        r.status = status;
        r.value  = value;
        r.last   = last;
        due_results.push_back(r);
    endtask

    // ring update for one accepted request, queues the results it causes
    task automatic advance_deque(input logic [2:0] func, input logic [31:0] value);
        case (func)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                if (count >= DEPTH) begin
                    expect_result(deq_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    if (func == deq_pkg::OP_PUSH_FRONT) begin
                        front = (front + DEPTH - 1) % DEPTH;
                        ring[front] = value;
                    end else begin
                        ring[(front + count) % DEPTH] = value;
                    end
                    count++;
                    expect_result(deq_pkg::ST_OK, '0, 1'b1);
                end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                if (count == 0) begin
                    expect_result(deq_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    if (func == deq_pkg::OP_POP_FRONT) begin
                        front = (front + 1) % DEPTH;
                    end
                    count--;
                    expect_result(deq_pkg::ST_OK, '0, 1'b1);
                end
            end
            deq_pkg::OP_DUMP: begin
                if (count == 0) begin
                    expect_result(deq_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < count; i++) begin
                        expect_result(deq_pkg::ST_OK, ring[(front + i) % DEPTH],
                                      i == count - 1);
                    end
                end
            end
            default: begin
                expect_result(deq_pkg::ST_INVALID, '0, 1'b1);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            due_results.delete();
            front       = 0;
            count       = 0;
            printed     = 0;
            error_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("result with none due: status %0d data %h last %b",
                                              m_tuser, m_tdata, m_tlast));
                end else begin
                    oldest = due_results.pop_front();
                    if (m_tuser !== oldest.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tuser, oldest.status));
                    end
                    if (m_tdata !== oldest.value) begin
                        report_mismatch($sformatf("item_value %h, expected %h",
                                                  m_tdata, oldest.value));
                    end
                    if (m_tlast !== oldest.last) begin
                        report_mismatch($sformatf("last %b, expected %b",
                                                  m_tlast, oldest.last));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                advance_deque(s_tuser, s_tdata);
            end
        end
        outstanding <= due_results.size();
    end

endmodule

[dv/double_ended_queue_unit_test.sv]
module double_ended_queue_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH        = 16;
    localparam int          ITEM_TARGET  = 450;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          TAIL_CYCLES  = 20;
    localparam logic [2:0]  FUNC_TOP     = '1;
    localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX      = 32'h7fff_ffff;

    typedef enum int {
        EP_FILL,
        EP_DRAIN,
        EP_MIXED
    } episode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int error_count;
    int outstanding;
    int sent;
    int result_cnt;
    int idle_cycles;
    int push_cnt;
    int pop_cnt;
    int dump_cnt;
    int bad_cnt;
    bit long_hold;
    bit tx_calm;

    double_ended_queue_unit #(.DEPTH(DEPTH)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    double_ended_queue_checker #(.DEPTH(DEPTH)) result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial aclk = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) begin
            return 0;
        end
        if (roll < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            return VAL_MIN;
        end
        if (roll < 10) begin
            return VAL_MAX;
        end
        if (roll < 13) begin
            return '0;
        end
        if (roll < 16) begin
            return '1;
        end
        return $urandom();
    endfunction

    function automatic logic [2:0] pick_invalid();
        return 3'($urandom_range(deq_pkg::OP_INVALID, FUNC_TOP));
    endfunction

    function automatic logic [2:0] pick_func(episode_t ep);
        int         roll;
        logic [2:0] f;
        roll = $urandom_range(0, 99);
        case (ep)
            EP_FILL: begin
                if (roll < 45)      f = deq_pkg::OP_PUSH_FRONT;
                else if (roll < 90) f = deq_pkg::OP_PUSH_BACK;
                else if (roll < 96) f = deq_pkg::OP_DUMP;
                else                f = deq_pkg::OP_POP_FRONT;
            end
            EP_DRAIN: begin
                if (roll < 40)      f = deq_pkg::OP_POP_FRONT;
                else if (roll < 80) f = deq_pkg::OP_POP_BACK;
                else if (roll < 90) f = deq_pkg::OP_DUMP;
                else if (roll < 96) f = deq_pkg::OP_PUSH_BACK;
                else                f = pick_invalid();
            end
            default: begin
                if (roll < 20)      f = deq_pkg::OP_PUSH_FRONT;
                else if (roll < 40) f = deq_pkg::OP_PUSH_BACK;
                else if (roll < 60) f = deq_pkg::OP_POP_FRONT;
                else if (roll < 78) f = deq_pkg::OP_POP_BACK;
                else if (roll < 92) f = deq_pkg::OP_DUMP;
                else                f = pick_invalid();
            end
        endcase
        return f;
    endfunction

    // offer one request and wait for it to be taken; valid stays high if no gap follows
    task automatic send(input logic [2:0] func, input logic [31:0] value);
        int gap;
        s_tuser  <= func;
        s_tdata  <= value;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
        case (func)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: push_cnt++;
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:   pop_cnt++;
            deq_pkg::OP_DUMP:                              dump_cnt++;
            default:                                       bad_cnt++;
        endcase
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // receiver side: random ready pattern plus one long hold on request
    initial begin
        int hold_left;
        int run_left;
        int gap_left;
        hold_left = 0;
        run_left  = 0;
        gap_left  = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                long_hold = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_tready <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                m_tready <= 1'b0;
            end else begin
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                       : $urandom_range(0, 12);
                gap_left = pick_gap(1'b0);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            result_cnt <= result_cnt + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        episode_t ep;
        int       roll;
        int       ep_len;
        long_hold = 1'b0;
        tx_calm   = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        aresetn  <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queue cases
        send(deq_pkg::OP_DUMP, $urandom());
        send(deq_pkg::OP_POP_FRONT, $urandom());
        send(deq_pkg::OP_POP_BACK, $urandom());
        // extremes, front insert wraps the pointer backward
        send(deq_pkg::OP_PUSH_FRONT, VAL_MIN);
        send(deq_pkg::OP_PUSH_BACK, VAL_MAX);
        send(deq_pkg::OP_PUSH_FRONT, '0);
        send(deq_pkg::OP_PUSH_BACK, '1);
        send(deq_pkg::OP_DUMP, $urandom());
        for (int f = deq_pkg::OP_INVALID; f <= FUNC_TOP; f++) begin
            send(3'(f), $urandom());
        end
        send(deq_pkg::OP_POP_BACK, $urandom());
        send(deq_pkg::OP_DUMP, $urandom());
        send(deq_pkg::OP_POP_FRONT, $urandom());
        send(deq_pkg::OP_DUMP, $urandom());
        send(deq_pkg::OP_POP_FRONT, $urandom());
        send(deq_pkg::OP_POP_BACK, $urandom());
        send(deq_pkg::OP_DUMP, $urandom());
        send(deq_pkg::OP_PUSH_BACK, VAL_MAX);
        send(deq_pkg::OP_DUMP, $urandom());
        send(deq_pkg::OP_POP_FRONT, $urandom());

        // fill past full, the pushes offered while the output is held off
        wait_drained();
        long_hold = 1'b1;
        tx_calm   = 1'b1;
        repeat (DEPTH + 4) begin
            send($urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
                 pick_value());
        end
        send(deq_pkg::OP_DUMP, $urandom());
        tx_calm = 1'b0;
        wait_drained();

        while (sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 35)      ep = EP_FILL;
            else if (roll < 60) ep = EP_DRAIN;
            else                ep = EP_MIXED;
            tx_calm = ($urandom_range(0, 3) == 0);
            ep_len  = $urandom_range(4, 24);
            repeat (ep_len) begin
                send(pick_func(ep), pick_value());
            end
            if ($urandom_range(0, 2) == 0) begin
                send(deq_pkg::OP_DUMP, $urandom());
            end
            if ($urandom_range(0, 5) == 0) begin
                wait_drained();
            end
        end
        tx_calm = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests (%0d push, %0d pop, %0d dump, %0d invalid), %0d results",
                 sent, push_cnt, pop_cnt, dump_cnt, bad_cnt, result_cnt);
        $display("queue filled past capacity under a %0d-cycle output hold, drained repeatedly",
                 HOLD_CYCLES);
        if (error_count == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
